[rtl/ehe_pkg.sv]
`default_nettype none
package ehe_pkg;

	localparam int BUDGET_W = 17;
	localparam int Q_DEPTH = 4;

	// Bytes held back from the buffer size when a string starts.
	localparam int BUDGET_RESERVE = 6;
	localparam logic [15:0] OUT_LEN_RESET = 16'd1024;

	// Configuration register indexes.
	localparam logic CFG_FONT_EN = 1'b0;
	localparam logic CFG_OUT_LEN = 1'b1;

	localparam logic [7:0] CH_LT = 8'h3C;
	localparam logic [7:0] CH_GT = 8'h3E;
	localparam logic [7:0] CH_AMP = 8'h26;
	localparam logic [7:0] CH_QUOT = 8'h22;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_DEL = 8'h7F;

	typedef enum logic [2:0] {
		TK_CHAR,
		TK_LT,
		TK_GT,
		TK_AMP,
		TK_QUOT,
		TK_TERM
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t   kind;
		logic [7:0]  ch;
		logic        term;
	} ehe_tok_t;

	// Font table, control-code rows for 0x00..0x1F and 0x80..0x9F.
	localparam logic [7:0] FONT_LO [32] = '{
		8'h00, 8'h23, 8'h23, 8'h23, 8'h23, 8'h2E, 8'h23, 8'h23,
		8'h23, 8'h09, 8'h0A, 8'h23, 8'h20, 8'h0D, 8'h2E, 8'h2E,
		8'h5B, 8'h5D, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35,
		8'h36, 8'h37, 8'h38, 8'h39, 8'h2E, 8'h3C, 8'h3D, 8'h3E
	};
	localparam logic [7:0] FONT_HI [32] = '{
		8'h3C, 8'h3D, 8'h3E, 8'h23, 8'h23, 8'h2E, 8'h23, 8'h23,
		8'h23, 8'h23, 8'h20, 8'h23, 8'h20, 8'h3E, 8'h2E, 8'h2E,
		8'h5B, 8'h5D, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35,
		8'h36, 8'h37, 8'h38, 8'h39, 8'h2E, 8'h3C, 8'h3D, 8'h3E
	};

	// The printable halves of the table repeat ASCII, with DEL shown as '<'.
	function automatic logic [7:0] font_map(input logic [7:0] c);
		logic [7:0] r;
		if (c[6:5] == 2'b00) begin
			r = c[7] ? FONT_HI[c[4:0]] : FONT_LO[c[4:0]];
		end else if (c[6:0] == CH_DEL[6:0]) begin
			r = CH_LT;
		end else begin
			r = {1'b0, c[6:0]};
		end
		return r;
	endfunction

	function automatic logic [2:0] body_len(input tok_kind_t k);
		logic [2:0] n;
		case (k)
			TK_CHAR: n = 3'd1;
			TK_LT:   n = 3'd4;
			TK_GT:   n = 3'd4;
			TK_AMP:  n = 3'd5;
			TK_QUOT: n = 3'd6;
			TK_TERM: n = 3'd0;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] body_byte(input tok_kind_t k, input logic [7:0] c,
			input logic [2:0] idx);
		logic [7:0] b;
		b = CH_NUL;
		case (k)
			TK_CHAR: b = c;
			TK_LT: begin
				case (idx)
					3'd0:    b = CH_AMP;
					3'd1:    b = 8'h6C;
					3'd2:    b = 8'h74;
					default: b = CH_SEMI;
				endcase
			end
			TK_GT: begin
				case (idx)
					3'd0:    b = CH_AMP;
					3'd1:    b = 8'h67;
					3'd2:    b = 8'h74;
					default: b = CH_SEMI;
				endcase
			end
			TK_AMP: begin
				case (idx)
					3'd0:    b = CH_AMP;
					3'd1:    b = 8'h61;
					3'd2:    b = 8'h6D;
					3'd3:    b = 8'h70;
					default: b = CH_SEMI;
				endcase
			end
			TK_QUOT: begin
				case (idx)
					3'd0:    b = CH_AMP;
					3'd1:    b = 8'h71;
					3'd2:    b = 8'h75;
					3'd3:    b = 8'h6F;
					3'd4:    b = 8'h74;
					default: b = CH_SEMI;
				endcase
			end
			default: b = CH_NUL;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

[rtl/ehe_front.sv]
`default_nettype none
module ehe_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [15:0]      cfg_wdata,
	input  wire logic             in_valid,
	input  wire logic [7:0]       in_char,
	input  wire logic             in_first,
	input  wire logic             in_eot,
	output logic                  in_ready,
	input  wire logic             q_full,
	output logic                  push,
	output ehe_pkg::ehe_tok_t     push_tok
);
	import ehe_pkg::*;

	logic                        font_en_q;
	logic [15:0]                 out_len_q;
	logic signed [BUDGET_W-1:0]  budget_q;
	logic                        done_q;

	logic signed [BUDGET_W-1:0]  budget_eff;
	logic signed [BUDGET_W-1:0]  budget_nxt;
	logic                        done_eff;
	logic                        done_nxt;
	logic [7:0]                  mapped;
	tok_kind_t                   kind;
	logic                        accept;

	assign in_ready = !q_full;
	assign accept = in_valid && in_ready;

	always_comb begin
		budget_eff = in_first ?
			($signed({1'b0, out_len_q}) - BUDGET_W'(BUDGET_RESERVE)) : budget_q;
		done_eff = in_first ? 1'b0 : done_q;
		mapped = font_en_q ? font_map(in_char) : in_char;
		case (mapped)
			CH_LT:   kind = TK_LT;
			CH_GT:   kind = TK_GT;
			CH_AMP:  kind = TK_AMP;
			CH_QUOT: kind = TK_QUOT;
			default: kind = TK_CHAR;
		endcase
		push = 1'b0;
		push_tok.kind = TK_TERM;
		push_tok.ch = mapped;
		push_tok.term = 1'b1;
		budget_nxt = budget_eff;
		done_nxt = done_eff;
		if (accept && !done_eff) begin
			push = 1'b1;
			if (budget_eff > 0 && in_char != CH_NUL) begin
				budget_nxt = budget_eff - $signed({{(BUDGET_W-3){1'b0}}, body_len(kind)});
				push_tok.kind = kind;
				push_tok.term = (budget_nxt <= 0) || in_eot;
				done_nxt = push_tok.term;
			end else begin
				done_nxt = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			font_en_q <= 1'b0;
			out_len_q <= OUT_LEN_RESET;
			budget_q <= '0;
			done_q <= 1'b1;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_FONT_EN: font_en_q <= cfg_wdata[0];
					CFG_OUT_LEN: out_len_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (accept) begin
				budget_q <= budget_nxt;
				done_q <= done_nxt;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/ehe_queue.sv]
`default_nettype none
module ehe_queue #(
	parameter int QDepth = ehe_pkg::Q_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire ehe_pkg::ehe_tok_t push_tok,
	output logic                   full,
	input  wire logic              pop,
	output logic                   head_valid,
	output ehe_pkg::ehe_tok_t      head_tok
);
	import ehe_pkg::*;

	localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
	localparam int CntW = $clog2(QDepth + 1);

	ehe_tok_t            mem_q [QDepth];
	logic [PtrW-1:0]     wr_ptr_q;
	logic [PtrW-1:0]     rd_ptr_q;
	logic [CntW-1:0]     count_q;
	logic                do_push;
	logic                do_pop;

	assign full = (count_q == CntW'(QDepth));
	assign head_valid = (count_q != '0);
	assign head_tok = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/ehe_back.sv]
`default_nettype none
module ehe_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              head_valid,
	input  wire ehe_pkg::ehe_tok_t head_tok,
	output logic                   pop,
	output logic                   out_valid,
	output logic [7:0]             out_byte,
	output logic                   out_last,
	input  wire logic              out_ready
);
	import ehe_pkg::*;

	logic [2:0]  idx_q;
	logic        valid_q;
	logic [7:0]  byte_q;
	logic        last_q;

	logic [2:0]  blen;
	logic [2:0]  total;
	logic        load;
	logic        is_last;
	logic [7:0]  cur_byte;

	always_comb begin
		blen = body_len(head_tok.kind);
		total = blen + {2'b00, head_tok.term};
		is_last = (idx_q == total - 3'd1);
		cur_byte = (idx_q < blen) ? body_byte(head_tok.kind, head_tok.ch, idx_q) : CH_NUL;
		load = head_valid && (!valid_q || out_ready);
		pop = load && is_last;
	end

	assign out_valid = valid_q;
	assign out_byte = byte_q;
	assign out_last = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= cur_byte;
			last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q <= is_last ? 3'd0 : idx_q + 3'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/html_entity_escaper.sv]
// Escapes one character per input beat into up to seven output bytes.
// Items pass through the token queue and then the registered output stage.
// Throughput: one output byte per cycle while m_tready is high; an item produces
// one byte for a plain character and up to seven for an entity plus terminator.
// A token queue, four entries by default, lets input run ahead of the expansion.
// Reset: no string is open, budget is zero, font mapping off, buffer size 1024.
`default_nettype none
module html_entity_escaper #(
	parameter int QDepth = ehe_pkg::Q_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_char
	input  wire logic        s_tlast,   // end_of_text
	input  wire logic [0:0]  s_tuser,   // [0] first_char
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [7:0] out_byte
	output logic             m_tlast    // run_last
);
	import ehe_pkg::*;

	logic      q_full;
	logic      push;
	ehe_tok_t  push_tok;
	logic      pop;
	logic      head_valid;
	ehe_tok_t  head_tok;

	ehe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_tvalid),
		.in_char   (s_tdata),
		.in_first  (s_tuser[0]),
		.in_eot    (s_tlast),
		.in_ready  (s_tready),
		.q_full    (q_full),
		.push      (push),
		.push_tok  (push_tok)
	);

	ehe_queue #(.QDepth(QDepth)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_tok   (push_tok),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_tok   (head_tok)
	);

	ehe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_tok   (head_tok),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_byte   (m_tdata),
		.out_last   (m_tlast),
		.out_ready  (m_tready)
	);

	// A zero byte is only ever the terminator, which always closes its item.
	a_term_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata == CH_NUL) |-> m_tlast)
		else $error("terminator byte without tlast");

	// With nothing queued, a free output stage cannot produce a beat.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid && (!m_tvalid || m_tready) |=> !m_tvalid)
		else $error("output beat with empty token queue");

	// Nothing is pushed into a full queue, since input is held off.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !push)
		else $error("push into full token queue");

endmodule
`default_nettype wire

[verif/tb_html_entity_escaper.sv]
`timescale 1ns / 1ps
module tb_html_entity_escaper;

	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_STALL = 400;
	localparam int BUDGET_RESERVE = 6;

	localparam logic [7:0] ASC_NUL = 8'h00;
	localparam logic [7:0] ASC_LT = 8'h3C;
	localparam logic [7:0] ASC_GT = 8'h3E;
	localparam logic [7:0] ASC_AMP = 8'h26;
	localparam logic [7:0] ASC_QUOT = 8'h22;
	localparam logic [7:0] ASC_DEL = 8'h7F;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
	} out_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;    // [7:0] in_char
	logic        s_tlast = 1'b0;  // end_of_text
	logic [0:0]  s_tuser = '0;    // [0] first_char
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;         // [7:0] out_byte
	logic        m_tlast;         // run_last

	html_entity_escaper dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	// Escaper state as the testbench sees it.
	logic        font_on = 1'b0;
	logic [15:0] buf_len = 16'd1024;
	int          budget = 0;
	logic        string_closed = 1'b1;

	out_beat_t expected_bytes[$];
	int errors = 0;
	int cycle = 0;
	int accepted_items = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int stall_req = 0;
	int stall_seen = 0;
	int stall_left = 0;

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > CYCLE_LIMIT) begin
			$display("html_entity_escaper regression: fail");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		$display("ERROR cycle %0d: %s", cycle, what);
		errors++;
	endtask

	// Game font glyph for each code; control rows differ only in their low half.
	function automatic logic [7:0] glyph(input logic [7:0] c);
		logic [4:0] idx;
		logic [7:0] g;
		idx = c[4:0];
		if (c[6:5] != 2'b00) begin
			g = (c[6:0] == ASC_DEL[6:0]) ? ASC_LT : {1'b0, c[6:0]};
		end else if (idx >= 5'd16) begin
			case (idx)
				5'd16: g = "[";
				5'd17: g = "]";
				5'd28: g = ".";
				5'd29: g = "<";
				5'd30: g = "=";
				5'd31: g = ">";
				default: g = 8'h30 + 8'(idx - 5'd18);
			endcase
		end else if (!c[7]) begin
			case (idx)
				5'd0: g = ASC_NUL;
				5'd5, 5'd14, 5'd15: g = ".";
				5'd9: g = 8'h09;
				5'd10: g = 8'h0A;
				5'd12: g = " ";
				5'd13: g = 8'h0D;
				default: g = "#";
			endcase
		end else begin
			case (idx)
				5'd0: g = "<";
				5'd1: g = "=";
				5'd2: g = ">";
				5'd5, 5'd14, 5'd15: g = ".";
				5'd10, 5'd12: g = " ";
				5'd13: g = ">";
				default: g = "#";
			endcase
		end
		return g;
	endfunction

	function automatic void predict_escape(input logic [7:0] raw, input logic first,
			input logic eot);
		logic [7:0] c;
		logic [7:0] burst[$];
		string seq;
		out_beat_t e;
		accepted_items++;
		if (first) begin
			budget = int'(buf_len) - BUDGET_RESERVE;
			string_closed = 1'b0;
		end
		if (string_closed)
			return;
		if (budget > 0 && raw != ASC_NUL) begin
			c = font_on ? glyph(raw) : raw;
			case (c)
				ASC_LT: seq = "&lt;";
				ASC_GT: seq = "&gt;";
				ASC_AMP: seq = "&amp;";
				ASC_QUOT: seq = "&quot;";
				default: seq = "";
			endcase
			if (seq.len() == 0)
				burst.push_back(c);
			for (int i = 0; i < seq.len(); i++)
				burst.push_back(seq[i]);
			budget -= burst.size();
			if (budget <= 0 || eot) begin
				burst.push_back(ASC_NUL);
				string_closed = 1'b1;
			end
		end else begin
			burst.push_back(ASC_NUL);
			string_closed = 1'b1;
		end
		for (int i = 0; i < burst.size(); i++) begin
			e.out_byte = burst[i];
			e.run_last = (i == burst.size() - 1);
			expected_bytes.push_back(e);
		end
	endfunction

	// Input beats are predicted before output beats are checked at the same edge.
	always @(posedge clk) begin
		out_beat_t e;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predict_escape(s_tdata, s_tuser[0], s_tlast);
			if (m_tvalid && m_tready) begin
				if (expected_bytes.size() == 0) begin
					report_mismatch($sformatf("unexpected beat 0x%02h last %0b",
						m_tdata, m_tlast));
				end else begin
					e = expected_bytes.pop_front();
					if (m_tdata !== e.out_byte)
						report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
							m_tdata, e.out_byte));
					if (m_tlast !== e.run_last)
						report_mismatch($sformatf("run_last %0b, expected %0b",
							m_tlast, e.run_last));
				end
			end
		end
	end

	always @(negedge clk) begin
		if (stall_req != stall_seen) begin
			stall_seen <= stall_req;
			stall_left <= LONG_STALL;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Called and returns at a falling edge.
	task automatic send_char(input logic [7:0] c, input logic first, input logic eot);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= eot;
		s_tuser <= first;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Items dropped on a closed string produce nothing, so allow them time to drain too.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == ehe_pkg::CFG_FONT_EN)
			font_on = val[0];
		else
			buf_len = val;
	endtask

	function automatic logic [7:0] pick_char();
		int roll;
		logic [7:0] c;
		roll = $urandom_range(99);
		if (roll < 30) begin
			case ($urandom_range(3))
				0: c = ASC_LT;
				1: c = ASC_GT;
				2: c = ASC_AMP;
				default: c = ASC_QUOT;
			endcase
		end else if (roll < 80) begin
			c = 8'($urandom_range(8'h7E, 8'h20));
		end else if (roll < 95) begin
			c = 8'($urandom_range(255, 1));
		end else begin
			c = ASC_NUL;
		end
		return c;
	endfunction

	task automatic test_escapes();
		write_reg(ehe_pkg::CFG_FONT_EN, 16'd0);
		write_reg(ehe_pkg::CFG_OUT_LEN, 16'd1024);
		send_char("A", 1'b1, 1'b0);
		send_char(ASC_LT, 1'b0, 1'b0);
		send_char(ASC_GT, 1'b0, 1'b0);
		send_char(ASC_AMP, 1'b0, 1'b0);
		send_char(ASC_QUOT, 1'b0, 1'b0);
		send_char(8'hFF, 1'b0, 1'b0);
		send_char(ASC_DEL, 1'b0, 1'b0);
		send_char(8'h01, 1'b0, 1'b1);
	endtask

	task automatic test_font_map();
		write_reg(ehe_pkg::CFG_FONT_EN, 16'd1);
		send_char(8'h1D, 1'b1, 1'b0);
		send_char(8'h80, 1'b0, 1'b0);
		send_char(8'hA2, 1'b0, 1'b0);
		send_char(8'h8D, 1'b0, 1'b0);
		send_char(8'h05, 1'b0, 1'b0);
		send_char(ASC_DEL, 1'b0, 1'b0);
		send_char(8'hFF, 1'b0, 1'b1);
		// A zero character ends the string even with the font table on.
		send_char(8'h26, 1'b1, 1'b0);
		send_char(ASC_NUL, 1'b0, 1'b0);
	endtask

	task automatic test_terminations();
		write_reg(ehe_pkg::CFG_FONT_EN, 16'd0);
		send_char("x", 1'b1, 1'b0);
		send_char(ASC_NUL, 1'b0, 1'b0);
		send_char("y", 1'b0, 1'b1);
		send_char("z", 1'b1, 1'b1);
		// One byte of budget: the first character uses it up.
		write_reg(ehe_pkg::CFG_OUT_LEN, 16'd7);
		send_char("a", 1'b1, 1'b0);
		send_char("b", 1'b0, 1'b0);
		// The quote entity overdraws a budget of four and closes the string.
		write_reg(ehe_pkg::CFG_OUT_LEN, 16'd10);
		send_char(ASC_QUOT, 1'b1, 1'b0);
	endtask

	task automatic test_buffer_sizes();
		write_reg(ehe_pkg::CFG_OUT_LEN, 16'd0);
		send_char("a", 1'b1, 1'b0);
		write_reg(ehe_pkg::CFG_OUT_LEN, 16'd6);
		send_char(ASC_LT, 1'b1, 1'b1);
		write_reg(ehe_pkg::CFG_OUT_LEN, 16'hFFFF);
		send_char("q", 1'b1, 1'b0);
		send_char("r", 1'b0, 1'b1);
	endtask

	task automatic test_backpressure();
		write_reg(ehe_pkg::CFG_OUT_LEN, 16'd1024);
		idle_pct = 0;
		stall_pct = 0;
		stall_req++;
		for (int i = 0; i < 24; i++)
			send_char(pick_char() | 8'h01, i == 0, i == 23);
		wait_idle();
	endtask

	task automatic test_random_strings(input int n, input int send_idle, input int recv_stall);
		int goal;
		int len;
		logic eot_on;
		write_reg(ehe_pkg::CFG_FONT_EN, 16'($urandom_range(1)));
		write_reg(ehe_pkg::CFG_OUT_LEN,
			($urandom_range(3) == 0) ? 16'd1024 : 16'(7 + $urandom_range(30)));
		idle_pct = send_idle;
		stall_pct = recv_stall;
		goal = accepted_items + n;
		while (accepted_items < goal) begin
			if ($urandom_range(99) < 80) begin
				len = $urandom_range(12, 1);
				eot_on = ($urandom_range(9) != 0);
				for (int i = 0; i < len; i++)
					send_char(pick_char(), i == 0, eot_on && i == len - 1);
			end else begin
				send_char(8'($urandom_range(255)), 1'($urandom_range(1)),
					1'($urandom_range(1)));
			end
		end
		wait_idle();
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_escapes();
		test_font_map();
		test_terminations();
		test_buffer_sizes();
		test_backpressure();
		test_random_strings(35, 0, 0);
		test_random_strings(35, 81, 0);
		test_random_strings(35, 0, 81);
		test_random_strings(35, 34, 34);
		stall_pct = 0;
		wait_idle();
		if (errors == 0 && expected_bytes.size() == 0) begin
			$display("html_entity_escaper regression: pass");
		end else begin
			$display("html_entity_escaper regression: fail");
		end
		$finish;
	end

endmodule
